@@ sv/rdq_pkg.sv @@
// Package holding the operation and status codes of the reversible deque unit.
package rdq_pkg;

  // Operation codes of an input request.
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_REVERSE    = 3'd4;

  // Status codes of a result.
  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;

  // Result field widths.
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned VALUE_W  = 32;

  typedef logic [STATUS_W-1:0] status_t;

endpackage

@@ sv/rdq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module rdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read share the clock.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/reversible_deque_unit.sv @@
// Top level of the reversible deque unit: a bounded double-ended queue in a ring RAM.
//
// The unit accepts a request when start is high and busy is low, then holds busy high for
// one cycle while the ring RAM returns the element that becomes the new end after a pop
// (the RAM read port is registered, so the element is only ready in the busy cycle).
// The result appears on the out_ ports for exactly one cycle, marked by out_valid, on the
// cycle after busy; the receiver cannot stall it, and a new request may be issued on that
// same cycle. Pushes write the RAM directly; the physical head and tail elements are kept
// in registers, so only pops need the read. A reverse swaps the logical ends in one step.
// Refused requests (pop on empty, push on full) leave the queue unchanged.
module reversible_deque_unit #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_kind,
  input  logic [31:0]              in_value,
  output logic                     out_valid,
  output rdq_pkg::status_t         out_status,
  output logic [4:0]               out_count,
  output logic [31:0]              out_front_value,
  output logic [31:0]              out_back_value
);

  import rdq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Control state.
  logic [AW-1:0]         head_r, head_nxt;
  logic [AW-1:0]         tail_r, tail_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  rev_r, rev_nxt;
  logic                  phase_r, phase_nxt;
  logic                  pop_head_r, pop_head_nxt;
  logic                  pop_tail_r, pop_tail_nxt;
  logic                  out_valid_r;
  status_t               status_r, status_nxt;

  // Cached physical end elements.
  logic [DATA_WIDTH-1:0] hv_r, hv_nxt;
  logic [DATA_WIDTH-1:0] tv_r, tv_nxt;

  // Result registers.
  status_t               out_status_r;
  logic [4:0]            out_count_r;
  logic [31:0]           out_front_r;
  logic [31:0]           out_back_r;

  // RAM port signals.
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [DATA_WIDTH-1:0] wval;
  logic [DATA_WIDTH+31:0] wval_ext;

  // Neighbouring ring positions.
  logic [AW-1:0]         head_up, head_dn, tail_up, tail_dn, tail_dn2;
  logic                  accept, is_empty, is_full, push_head, pop_head;
  logic [DATA_WIDTH-1:0] front_sel, back_sel;
  logic [DATA_WIDTH+31:0] front_ext, back_ext;
  logic [CW+4:0]         cnt_ext;

  assign head_up  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign head_dn  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign tail_up  = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + AW'(1);
  assign tail_dn  = (tail_r == '0) ? AW'(DEPTH - 1) : tail_r - AW'(1);
  assign tail_dn2 = (tail_dn == '0) ? AW'(DEPTH - 1) : tail_dn - AW'(1);

  assign accept    = start && !phase_r;
  assign is_empty  = (cnt_r == '0);
  assign is_full   = (cnt_r == CW'(DEPTH));
  assign push_head = (in_kind == KIND_PUSH_FRONT) == !rev_r;
  assign pop_head  = (in_kind == KIND_POP_FRONT) == !rev_r;

  // The pushed value is fitted to the element width.
  assign wval_ext = {{DATA_WIDTH{1'b0}}, in_value};
  assign wval     = wval_ext[DATA_WIDTH-1:0];

  // Request decode, ring pointer update and cache refresh.
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;
    rev_nxt      = rev_r;
    status_nxt   = status_r;
    pop_head_nxt = 1'b0;
    pop_tail_nxt = 1'b0;
    phase_nxt    = accept;
    hv_nxt       = hv_r;
    tv_nxt       = tv_r;
    ram_we       = 1'b0;
    ram_waddr    = tail_r;
    ram_raddr    = head_up;

    // Busy cycle: take the new end element from the RAM.
    if (pop_head_r) begin
      hv_nxt = ram_rdata;
    end
    if (pop_tail_r) begin
      tv_nxt = ram_rdata;
    end

    if (accept) begin
      status_nxt = STATUS_DONE;
      unique case (in_kind)
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          if (is_full) begin
            status_nxt = STATUS_PUSH_FULL;
          end else begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
            if (push_head) begin
              head_nxt  = head_dn;
              ram_waddr = head_dn;
              hv_nxt    = wval;
              if (is_empty) begin
                tv_nxt = wval;
              end
            end else begin
              tail_nxt  = tail_up;
              ram_waddr = tail_r;
              tv_nxt    = wval;
              if (is_empty) begin
                hv_nxt = wval;
              end
            end
          end
        end
        KIND_POP_FRONT, KIND_POP_BACK: begin
          if (is_empty) begin
            status_nxt = STATUS_POP_EMPTY;
          end else begin
            cnt_nxt = cnt_r - CW'(1);
            if (pop_head) begin
              head_nxt     = head_up;
              ram_raddr    = head_up;
              pop_head_nxt = 1'b1;
            end else begin
              tail_nxt     = tail_dn;
              ram_raddr    = tail_dn2;
              pop_tail_nxt = 1'b1;
            end
          end
        end
        KIND_REVERSE: begin
          rev_nxt = !rev_r;
        end
        default: begin
          status_nxt = STATUS_DONE;
        end
      endcase
    end
  end

  // Logical ends of the result, zero when the queue is empty.
  always_comb begin
    front_sel = rev_r ? tv_nxt : hv_nxt;
    back_sel  = rev_r ? hv_nxt : tv_nxt;
    if (is_empty) begin
      front_sel = '0;
      back_sel  = '0;
    end
  end

  assign front_ext = {32'd0, front_sel};
  assign back_ext  = {32'd0, back_sel};
  assign cnt_ext   = {5'd0, cnt_r};

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      rev_r       <= 1'b0;
      phase_r     <= 1'b0;
      pop_head_r  <= 1'b0;
      pop_tail_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      rev_r       <= rev_nxt;
      phase_r     <= phase_nxt;
      pop_head_r  <= pop_head_nxt;
      pop_tail_r  <= pop_tail_nxt;
      out_valid_r <= phase_r;
    end
  end

  // Payload registers: cache and result.
  always_ff @(posedge clk) begin
    hv_r     <= hv_nxt;
    tv_r     <= tv_nxt;
    status_r <= status_nxt;
    if (phase_r) begin
      out_status_r <= status_r;
      out_count_r  <= cnt_ext[4:0];
      out_front_r  <= front_ext[31:0];
      out_back_r   <= back_ext[31:0];
    end
  end

  // Ring storage.
  rdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wval),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy            = phase_r;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_count       = out_count_r;
  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;

  // A result only follows a busy cycle.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(phase_r))
    else $error("result strobe without a preceding busy cycle");

  // Busy lasts exactly one cycle per request.
  a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |=> !phase_r)
    else $error("busy held for more than one cycle");

  // The element count never passes the ring depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("element count exceeds depth");

  // An empty or full ring has its pointers together.
  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == CW'(DEPTH)) |-> (head_r == tail_r))
    else $error("head and tail disagree with the count");

  // A refused pop is only reported on an empty queue.
  a_pop_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_POP_EMPTY) |-> (out_count_r == 5'd0))
    else $error("pop refused with elements held");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the reversible deque unit, with a mirrored deque used for prediction.
`timescale 1ns / 1ps

module tb;
  import rdq_pkg::*;

  // Kind codes that the unit treats as no operation.
  localparam logic [2:0] KIND_RESERVED_5 = 3'd5;
  localparam logic [2:0] KIND_RESERVED_6 = 3'd6;
  localparam logic [2:0] KIND_RESERVED_7 = 3'd7;

  localparam int unsigned RING_DEPTH    = 16;
  localparam int unsigned RANDOM_ITEMS  = 1800;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned PENDING_DEPTH = 256;

  // Bias of a burst of random requests.
  localparam int BIAS_FILL    = 0;
  localparam int BIAS_DRAIN   = 1;
  localparam int BIAS_BALANCE = 2;

  typedef struct packed {
    status_t     status;
    logic [4:0]  count;
    logic [31:0] front_value;
    logic [31:0] back_value;
  } deque_result_t;

  // Mirror of the deque: predicts the result of each accepted request and checks
  // the results of the unit in order.
  class deque_mirror;
    logic [31:0]   ring [RING_DEPTH];
    logic [3:0]    head;
    logic [3:0]    tail;
    logic [4:0]    count;
    logic          reversed;
    deque_result_t expected_results [PENDING_DEPTH];
    int unsigned   wr_count;
    int unsigned   rd_count;
    int unsigned   mismatches;

    function new();
      head       = '0;
      tail       = '0;
      count      = '0;
      reversed   = 1'b0;
      wr_count   = 0;
      rd_count   = 0;
      mismatches = 0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    // Apply one accepted request to the mirror and queue the result it should give.
    function void note_request(logic [2:0] kind, logic [31:0] value);
      deque_result_t res;
      logic          at_head;
      logic [31:0]   head_val;
      logic [31:0]   tail_val;
      res.status = STATUS_DONE;
      head_val   = '0;
      tail_val   = '0;
      if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) begin
        if (count >= RING_DEPTH) begin
          res.status = STATUS_PUSH_FULL;
        end else begin
          at_head = (kind == KIND_PUSH_FRONT) == !reversed;
          if (at_head) begin
            head       = head - 4'd1;
            ring[head] = value;
          end else begin
            ring[tail] = value;
            tail       = tail + 4'd1;
          end
          count = count + 5'd1;
        end
      end else if (kind == KIND_POP_FRONT || kind == KIND_POP_BACK) begin
        if (count == 0) begin
          res.status = STATUS_POP_EMPTY;
        end else begin
          at_head = (kind == KIND_POP_FRONT) == !reversed;
          if (at_head) head = head + 4'd1;
          else tail = tail - 4'd1;
          count = count - 5'd1;
        end
      end else if (kind == KIND_REVERSE) begin
        reversed = !reversed;
      end
      if (count != 0) begin
        head_val = ring[head];
        tail_val = ring[tail - 4'd1];
      end
      res.count       = count;
      res.front_value = reversed ? tail_val : head_val;
      res.back_value  = reversed ? head_val : tail_val;
      expected_results[wr_count % PENDING_DEPTH] = res;
      wr_count++;
    endfunction

    // Compare one result of the unit with the oldest prediction.
    function void check_result(status_t status, logic [4:0] cnt, logic [31:0] front_value,
                               logic [31:0] back_value);
      deque_result_t exp;
      if (wr_count == rd_count) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb: unexpected result at %0t: status %0d count %0d front %h back %h",
                   $time, status, cnt, front_value, back_value);
        return;
      end
      exp = expected_results[rd_count % PENDING_DEPTH];
      rd_count++;
      if (status !== exp.status || cnt !== exp.count || front_value !== exp.front_value ||
          back_value !== exp.back_value) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"tb: mismatch at %0t: expected status %0d count %0d front %h back %h,",
                    " got status %0d count %0d front %h back %h"},
                   $time, exp.status, exp.count, exp.front_value, exp.back_value,
                   status, cnt, front_value, back_value);
      end
    endfunction

    function int pending();
      return int'(wr_count - rd_count);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_kind;
  logic [31:0] in_value;
  logic        out_valid;
  status_t     out_status;
  logic [4:0]  out_count;
  logic [31:0] out_front_value;
  logic [31:0] out_back_value;

  deque_mirror mirror;

  reversible_deque_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_count       (out_count),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value)
  );

  // Clock generation.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Results are sampled at the edge that ends their cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      mirror.check_result(out_status, out_count, out_front_value, out_back_value);
    end
  end

  // Issue one request after the given idle gap and note it once it is accepted.
  task automatic send_request(input logic [2:0] kind, input logic [31:0] value, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    do @(posedge clk); while (busy);
    mirror.note_request(kind, value);
  endtask

  // Draw a request kind, leaning towards pushes or pops according to the bias.
  function automatic logic [2:0] draw_kind(int bias);
    int unsigned r;
    int unsigned push_share;
    logic        second;
    r          = $urandom_range(0, 99);
    second     = $urandom_range(0, 1);
    push_share = (bias == BIAS_FILL) ? 75 : (bias == BIAS_DRAIN) ? 25 : 50;
    if (r < 10) return KIND_REVERSE;
    if (r < 11) return KIND_RESERVED_5;
    if (r < 12) return KIND_RESERVED_6;
    if (r < 13) return KIND_RESERVED_7;
    if ($urandom_range(0, 99) < push_share)
      return second ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
    return second ? KIND_POP_BACK : KIND_POP_FRONT;
  endfunction

  // Draw an element, with the all-zero and all-one patterns now and then.
  function automatic logic [31:0] draw_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Main stimulus.
  initial begin
    int          burst_left;
    int          bias;
    logic        idle_on;
    logic [31:0] fill_value;

    mirror   = new();
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_kind  <= KIND_PUSH_FRONT;
    in_value <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: refused pops, reverse and reserved kinds on an empty queue,
    // then a fill to full with extreme elements and refused pushes.
    send_request(KIND_POP_FRONT, 32'h1234_5678, $urandom_range(0, 5));
    send_request(KIND_POP_BACK, 32'hFFFF_FFFF, $urandom_range(0, 5));
    send_request(KIND_REVERSE, 32'h0, $urandom_range(0, 5));
    send_request(KIND_RESERVED_5, 32'hA5A5_A5A5, $urandom_range(0, 5));
    send_request(KIND_RESERVED_6, 32'h5A5A_5A5A, 0);
    send_request(KIND_RESERVED_7, 32'hFFFF_FFFF, 0);
    for (int i = 0; i < RING_DEPTH; i++) begin
      case (i % 4)
        0: fill_value = 32'h0000_0000;
        1: fill_value = 32'hFFFF_FFFF;
        2: fill_value = 32'hAAAA_5555;
        default: fill_value = 32'h5555_AAAA ^ i;
      endcase
      send_request((i % 2) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, fill_value,
                   (i < 8) ? 0 : $urandom_range(0, 5));
    end
    send_request(KIND_PUSH_FRONT, 32'hDEAD_0001, $urandom_range(0, 5));
    send_request(KIND_PUSH_BACK, 32'hDEAD_0002, 0);
    send_request(KIND_REVERSE, 32'h0, $urandom_range(0, 5));

    // Random part in bursts that push the queue towards full, towards empty or
    // leave it balanced, with and without idle gaps.
    burst_left = 0;
    bias       = BIAS_BALANCE;
    idle_on    = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(20, 60);
        bias       = $urandom_range(BIAS_FILL, BIAS_BALANCE);
        idle_on    = $urandom_range(0, 2) != 0;
      end
      burst_left--;
      send_request(draw_kind(bias), draw_value(), idle_on ? $urandom_range(0, 5) : 0);
    end
    start <= 1'b0;

    // Drain the outstanding results, then watch a little longer for strays.
    while (mirror.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog for a unit that stops answering.
  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
